// ===== design/alpl_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// alpl_pkg
// Shared widths, depth and commands of the arc-length parameter lookup.
// ----------------------------------------------------------------------------
package alpl_pkg;

  localparam int TABLE_DEPTH = 128;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = 8;
  localparam int PARAM_W     = 17;
  localparam int LEN_W       = 32;
  localparam int PROD_W      = LEN_W + PARAM_W;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

endpackage : alpl_pkg
`default_nettype wire

// ===== design/alpl_ifs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// alpl channel interfaces
// Request, result and register write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface alpl_req_if;
  import alpl_pkg::*;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [6:0]         entry_index;
  logic [PARAM_W-1:0] entry_param;
  logic [LEN_W-1:0]   entry_length;
  logic [LEN_W-1:0]   query_length;

  modport source (output valid, cmd, entry_index, entry_param, entry_length,
                  query_length, input ready);
  modport sink   (input valid, cmd, entry_index, entry_param, entry_length,
                  query_length, output ready);
endinterface : alpl_req_if

interface alpl_rsp_if;
  import alpl_pkg::*;
  logic               valid;
  logic               ready;
  logic [PARAM_W-1:0] result_param;
  logic [LEN_W-1:0]   used_length;
  logic               was_beyond;

  modport source (output valid, result_param, used_length, was_beyond,
                  input ready);
  modport sink   (input valid, result_param, used_length, was_beyond,
                  output ready);
endinterface : alpl_rsp_if

interface alpl_cfg_if;
  import alpl_pkg::*;
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] entry_count;

  modport source (output valid, entry_count, input ready);
  modport sink   (input valid, entry_count, output ready);
endinterface : alpl_cfg_if
`default_nettype wire

// ===== design/alpl_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// alpl_div
// Restoring divider, one quotient bit per cycle. The quotient is known to
// fit in PARAM_W bits (numerator below den << PARAM_W).
// ----------------------------------------------------------------------------
module alpl_div
  import alpl_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [PROD_W-1:0]  num,
  input  wire logic [LEN_W-1:0]   den,
  output logic                    done,
  output logic [PARAM_W-1:0]      quo
);

  localparam int STEP_W = $clog2(PARAM_W + 1);

  logic [LEN_W-1:0]   rem;
  logic [PARAM_W-1:0] low;
  logic [STEP_W-1:0]  steps;
  logic [LEN_W:0]     trial;
  logic               fits;

  assign trial = {rem, low[PARAM_W-1]};
  assign fits  = trial >= {1'b0, den};
  assign quo   = low;

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
      done  <= 1'b0;
    end else begin
      done <= !start && (steps == STEP_W'(1));
      if (start) begin
        rem   <= num[PROD_W-1:PARAM_W];
        low   <= num[PARAM_W-1:0];
        steps <= STEP_W'(PARAM_W);
      end else if (steps != '0) begin
        // low shifts numerator bits out and quotient bits in
        rem   <= fits ? LEN_W'(trial - {1'b0, den}) : trial[LEN_W-1:0];
        low   <= {low[PARAM_W-2:0], fits};
        steps <= steps - STEP_W'(1);
      end
    end
  end

endmodule : alpl_div
`default_nettype wire

// ===== design/arc_length_param_lookup.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// arc_length_param_lookup
// Arc length to curve parameter lookup over a loadable table.
// ----------------------------------------------------------------------------
// A load beat writes one table entry and gives no result. A query beat
// reads the last active length, then scans the length memory downward
// from entry n-2 one entry per cycle until it finds one at or below the
// query (or reaches entry 0), reads the upper end of that segment, then
// steps through segment set-up, clamp and multiply and the serial divider
// (start, one step per quotient bit, done) before the result register is
// loaded. The scan reads from 1 to n-1 entries, and the next beat can be
// taken in the cycle the result is presented; a zero-length or decreasing
// segment skips the multiply and divider. The single-read-port table
// memories and the divider keep a new beat out until a query is through. A
// finished result sits in an output register, so the next beat is taken
// while it waits; a following result that finds it still held waits too.
// There is no clearing pass: entries read before they are loaded give
// undefined results.
// ----------------------------------------------------------------------------
module arc_length_param_lookup
  import alpl_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  alpl_req_if.sink   req,
  alpl_rsp_if.source rsp,
  alpl_cfg_if.sink   cfg
);

  typedef enum logic [2:0] {
    S_IDLE, S_LAST, S_SCAN, S_UPPER, S_CLAMP, S_MUL, S_DIV, S_FIN
  } state_t;

  state_t state;

  logic [CNT_W-1:0]   entry_count;
  logic [CNT_W-1:0]   n_act;
  logic [PARAM_W-1:0] param_mem [TABLE_DEPTH];
  logic [LEN_W-1:0]   len_mem   [TABLE_DEPTH];
  logic [PARAM_W-1:0] param_rd;
  logic [LEN_W-1:0]   len_rd;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  logic               req_fire;
  logic               hit;

  logic [LEN_W-1:0]   q;
  logic               beyond;
  logic [IDX_W-1:0]   scan_idx;
  logic [PARAM_W-1:0] u0;
  logic [LEN_W-1:0]   l0;
  logic [LEN_W-1:0]   span;
  logic [LEN_W-1:0]   offset;
  logic [PARAM_W-1:0] mag;
  logic               neg;
  logic               flat;
  logic [PROD_W-1:0]  prod;
  logic               div_start;
  logic               div_done;
  logic [PARAM_W-1:0] quo;

  logic               out_valid;
  logic [PARAM_W-1:0] out_param;
  logic [LEN_W-1:0]   out_len;
  logic               out_beyond;

  assign req.ready = (state == S_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign wr_en     = req_fire && (req.cmd == CMD_LOAD);
  assign cfg.ready = 1'b1;

  assign rsp.valid        = out_valid;
  assign rsp.result_param = out_param;
  assign rsp.used_length  = out_len;
  assign rsp.was_beyond   = out_beyond;

  always_comb begin
    if (entry_count < CNT_W'(2)) begin
      n_act = CNT_W'(2);
    end else if (entry_count > CNT_W'(TABLE_DEPTH)) begin
      n_act = CNT_W'(TABLE_DEPTH);
    end else begin
      n_act = entry_count;
    end
  end

  // scanning downward, the first entry at or below q is the highest-indexed one
  assign hit = (len_rd <= q) || (scan_idx == '0);

  always_comb begin
    rd_addr = scan_idx;
    case (state)
      S_IDLE: rd_addr = IDX_W'(n_act - CNT_W'(1));
      S_SCAN: rd_addr = hit ? scan_idx + IDX_W'(1) : scan_idx - IDX_W'(1);
      default: rd_addr = scan_idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      param_mem[req.entry_index[IDX_W-1:0]] <= req.entry_param;
      len_mem[req.entry_index[IDX_W-1:0]]   <= req.entry_length;
    end
    param_rd <= param_mem[rd_addr];
    len_rd   <= len_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= CNT_W'(2);
    end else if (cfg.valid && cfg.ready) begin
      entry_count <= cfg.entry_count;
    end
  end

  alpl_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (prod),
    .den   (span),
    .done  (div_done),
    .quo   (quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      div_start <= 1'b0;
    end else begin
      // the product and div_start are both registered on leaving S_MUL, so the divider sees them together
      div_start <= (state == S_MUL);
      if (state == S_FIN && (!out_valid || rsp.ready)) begin
        out_valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_fire && req.cmd == CMD_QUERY) begin
            q        <= req.query_length;
            scan_idx <= IDX_W'(n_act - CNT_W'(2));
            state    <= S_LAST;
          end
        end
        S_LAST: begin
          // len_rd is the last active length
          if (q > len_rd) begin
            q      <= '0;
            beyond <= 1'b1;
          end else begin
            beyond <= 1'b0;
          end
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (hit) begin
            u0    <= param_rd;
            l0    <= len_rd;
            state <= S_UPPER;
          end else begin
            scan_idx <= scan_idx - IDX_W'(1);
          end
        end
        S_UPPER: begin
          flat   <= (len_rd <= l0);
          span   <= len_rd - l0;
          offset <= (q > l0) ? q - l0 : '0;
          neg    <= (param_rd < u0);
          mag    <= (param_rd < u0) ? u0 - param_rd : param_rd - u0;
          state  <= S_CLAMP;
        end
        S_CLAMP: begin
          if (offset > span) begin
            offset <= span;
          end
          state <= flat ? S_FIN : S_MUL;
        end
        S_MUL: begin
          prod  <= PROD_W'(offset) * PROD_W'(mag);
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid || rsp.ready) begin
            if (flat) begin
              out_param <= u0;
            end else if (neg) begin
              out_param <= u0 - quo;
            end else begin
              out_param <= u0 + quo;
            end
            out_len    <= q;
            out_beyond <= beyond;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule : arc_length_param_lookup
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the arc-length parameter lookup: loads tables,
// runs directed and random queries under bursty input and stalled output,
// and compares every result against a behavioural lookup of its own.
// ----------------------------------------------------------------------------
module tb;
  import alpl_pkg::*;

  localparam int          RANDOM_ITEMS  = 1250;
  localparam int          SETTLE_CYCLES = 200;
  localparam int unsigned CYCLE_LIMIT   = 2000000;
  localparam int          MAX_REPORTS   = 10;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_LONG} stall_mode_t;

  typedef struct packed {
    logic [PARAM_W-1:0] result_param;
    logic [LEN_W-1:0]   used_length;
    logic               was_beyond;
  } lookup_t;

  logic clk;
  logic rst;

  alpl_req_if req_ch ();
  alpl_rsp_if rsp_ch ();
  alpl_cfg_if cfg_ch ();

  arc_length_param_lookup DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // mirror of the block state
  logic [PARAM_W-1:0] param_mirror  [TABLE_DEPTH];
  logic [LEN_W-1:0]   length_mirror [TABLE_DEPTH];
  logic [CNT_W-1:0]   count_mirror = 8'd2;

  lookup_t     pending_lookups[$];
  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;

  stall_mode_t stall_mode   = STALL_NONE;
  int          stall_left   = 0;
  bit          sender_idles = 1'b1;
  int          gap_max      = 4;
  int          burst_left   = 0;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned active_entries(input logic [CNT_W-1:0] cnt);
    int unsigned n;
    n = cnt;
    if (n < 2) n = 2;
    if (n > TABLE_DEPTH) n = TABLE_DEPTH;
    return n;
  endfunction

  function automatic lookup_t lookup_param(input logic [LEN_W-1:0] query);
    int unsigned        n;
    int unsigned        seg;
    logic [LEN_W-1:0]   q;
    logic [LEN_W-1:0]   l0;
    logic [LEN_W-1:0]   l1;
    logic [PARAM_W-1:0] u0;
    logic [PARAM_W-1:0] u1;
    logic [63:0]        span;
    logic [63:0]        delta;
    logic [63:0]        mag;
    logic [63:0]        stepv;
    lookup_t            res;
    n = active_entries(count_mirror);
    q = query;
    res.was_beyond = 1'b0;
    if (q > length_mirror[n-1]) begin
      q = '0;
      res.was_beyond = 1'b1;
    end
    seg = 0;
    for (int i = 0; i + 2 <= n; i++) begin
      if (length_mirror[i] <= q) seg = i;
    end
    u0 = param_mirror[seg];
    u1 = param_mirror[seg+1];
    l0 = length_mirror[seg];
    l1 = length_mirror[seg+1];
    res.used_length = q;
    if (l1 <= l0) begin
      res.result_param = u0;
    end else begin
      span  = 64'(l1) - 64'(l0);
      delta = (q > l0) ? 64'(q) - 64'(l0) : 64'd0;
      if (delta > span) delta = span;
      if (u1 >= u0) begin
        mag   = 64'(u1 - u0);
        stepv = (delta * mag) / span;
        res.result_param = PARAM_W'(64'(u0) + stepv);
      end else begin
        mag   = 64'(u0 - u1);
        stepv = (delta * mag) / span;
        res.result_param = PARAM_W'(64'(u0) - stepv);
      end
    end
    return res;
  endfunction

  // request beats drive the mirror and the queue of expected lookups
  always @(posedge clk) begin
    if (!rst && req_ch.valid && req_ch.ready) begin
      if (req_ch.cmd == CMD_LOAD) begin
        param_mirror[req_ch.entry_index]  = req_ch.entry_param;
        length_mirror[req_ch.entry_index] = req_ch.entry_length;
      end else begin
        pending_lookups.insert(pending_lookups.size(), lookup_param(req_ch.query_length));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && cfg_ch.valid && cfg_ch.ready) count_mirror = cfg_ch.entry_count;
  end

  always @(posedge clk) begin
    lookup_t got;
    lookup_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got = '{rsp_ch.result_param, rsp_ch.used_length, rsp_ch.was_beyond};
      if (pending_lookups.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected result beat: param %h length %h beyond %b",
                   got.result_param, got.used_length, got.was_beyond);
      end else begin
        want = pending_lookups.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("mismatch: expected param %h length %h beyond %b, got %h %h %b",
                     want.result_param, want.used_length, want.was_beyond,
                     got.result_param, got.used_length, got.was_beyond);
        end
      end
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    case (stall_mode)
      STALL_NONE: begin
        rsp_ch.ready <= 1'b1;
      end
      STALL_RANDOM: begin
        rsp_ch.ready <= 1'($urandom_range(0, 1));
      end
      STALL_PERIODIC: begin
        rsp_ch.ready <= (cycle_count % 11) >= 4;
      end
      default: begin
        if (stall_left > 0) begin
          stall_left--;
          rsp_ch.ready <= 1'b0;
        end else begin
          rsp_ch.ready <= 1'b1;
          if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(5, 40);
        end
      end
    endcase
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_beat(input logic cmd, input logic [6:0] idx,
                           input logic [PARAM_W-1:0] prm, input logic [LEN_W-1:0] len,
                           input logic [LEN_W-1:0] qlen);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = sender_idles ? $urandom_range(0, gap_max) : 0;
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_ch.valid        <= 1'b1;
    req_ch.cmd          <= cmd;
    req_ch.entry_index  <= idx;
    req_ch.entry_param  <= prm;
    req_ch.entry_length <= len;
    req_ch.query_length <= qlen;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic load_entry(input logic [6:0] idx, input logic [PARAM_W-1:0] prm,
                            input logic [LEN_W-1:0] len);
    send_beat(CMD_LOAD, idx, prm, len, LEN_W'($urandom));
  endtask

  task automatic query_length(input logic [LEN_W-1:0] qlen);
    send_beat(CMD_QUERY, 7'($urandom), PARAM_W'($urandom), LEN_W'($urandom), qlen);
  endtask

  // loads give no result, so allow the block to finish before going on
  task automatic drain_lookups();
    req_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_entry_count(input logic [CNT_W-1:0] value);
    drain_lookups();
    cfg_ch.entry_count <= value;
    cfg_ch.valid       <= 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // two entries under the reset entry count, full-width extremes
  task automatic test_reset_count();
    load_entry(7'd0, 17'd0, 32'h0000_0000);
    load_entry(7'd1, 17'd65536, 32'hFFFF_FFFF);
    query_length(32'h0000_0000);
    query_length(32'h8000_0000);
    query_length(32'hFFFF_FFFF);
  endtask

  task automatic test_full_depth();
    write_entry_count(8'd128);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      load_entry(7'(i), (i == TABLE_DEPTH - 1) ? 17'd65536 : 17'(i * 516),
                 32'(i) * 32'h0204_0810);
    end
    query_length(32'hFFFF_FFF0);
    query_length(32'hFFFF_FFFF);
    query_length(32'h0204_0811);
    query_length(32'h7654_3210);
  endtask

  task automatic test_count_clamp();
    write_entry_count(8'd0);
    query_length(32'h0100_0000);
    write_entry_count(8'd1);
    query_length(32'h0300_0000);
    write_entry_count(8'd2);
    query_length(32'h0204_0810);
    write_entry_count(8'd255);
    query_length(32'hFFFF_FFF0);
    write_entry_count(8'd129);
    query_length(32'h9ABC_DEF0);
  endtask

  // below first length, non-monotone lengths, zero-length segment, beyond
  task automatic test_segment_cases();
    write_entry_count(8'd5);
    load_entry(7'd0, 17'd0, 32'h0000_1000);
    load_entry(7'd1, 17'd65536, 32'h0000_5000);
    load_entry(7'd2, 17'h02000, 32'h0000_3000);
    load_entry(7'd3, 17'h0FFFF, 32'h0000_3000);
    load_entry(7'd4, 17'h00100, 32'h0000_9000);
    query_length(32'h0000_0FFF);
    query_length(32'h0000_2000);
    query_length(32'h0000_4000);
    query_length(32'h0000_5000);
    query_length(32'h0000_9000);
    query_length(32'h0000_9001);
    write_entry_count(8'd4);
    query_length(32'h0000_3000);
    query_length(32'h0000_2FFF);
  endtask

  task automatic test_random_traffic();
    int unsigned      sent;
    int unsigned      n_eff;
    int unsigned      nq;
    int unsigned      kind;
    int unsigned      shape;
    int unsigned      pick;
    logic [CNT_W-1:0] cnt_val;
    logic [63:0]      acc;
    logic [63:0]      max_step;
    logic [LEN_W-1:0] len;
    logic [PARAM_W-1:0] prm;
    logic [LEN_W-1:0] q;
    logic [LEN_W-1:0] lo;
    logic [LEN_W-1:0] hi;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 70)      cnt_val = 8'($urandom_range(2, 12));
      else if (pick < 85) cnt_val = 8'($urandom_range(13, 40));
      else if (pick < 92) cnt_val = 8'($urandom_range(41, 128));
      else if (pick < 96) cnt_val = 8'($urandom_range(0, 1));
      else                cnt_val = 8'($urandom_range(129, 255));
      write_entry_count(cnt_val);
      n_eff = active_entries(cnt_val);
      stall_mode   = stall_mode_t'($urandom_range(0, 3));
      sender_idles = $urandom_range(0, 3) != 0;
      gap_max      = $urandom_range(1, 12);

      // mostly ascending tables; a few with repeats, noise or coarse steps
      shape = $urandom_range(0, 9);
      max_step = (64'h1_0000_0000 / n_eff) >> $urandom_range(0, 24);
      if (max_step == 0) max_step = 64'd1;
      acc = 64'd0;
      for (int i = 0; i < n_eff; i++) begin
        if (!(shape == 6 && $urandom_range(0, 2) == 0))
          acc = acc + $urandom_range(0, 32'(max_step - 1));
        case (shape)
          7:       len = LEN_W'($urandom);
          8:       len = LEN_W'($urandom_range(0, 3)) << 8;
          default: len = (acc > 64'hFFFF_FFFF) ? '1 : acc[LEN_W-1:0];
        endcase
        pick = $urandom_range(0, 9);
        prm = (pick == 0) ? 17'd0 : (pick == 1) ? 17'd65536 : 17'($urandom_range(0, 65536));
        load_entry(7'(i), prm, len);
        sent++;
      end

      nq = (n_eff > 40) ? $urandom_range(2, 6) : $urandom_range(4, 24);
      repeat (nq) begin
        if ($urandom_range(0, 9) == 0) begin
          load_entry(7'($urandom_range(0, TABLE_DEPTH - 1)),
                     17'($urandom_range(0, 65536)), LEN_W'($urandom));
          sent++;
        end
        lo = length_mirror[0];
        hi = length_mirror[n_eff-1];
        kind = $urandom_range(0, 11);
        case (kind)
          0, 1:    q = length_mirror[$urandom_range(0, n_eff - 1)];
          2:       q = LEN_W'($urandom);
          3:       q = (hi == '1) ? hi : hi + 1;
          4:       q = (lo == 0) ? lo : LEN_W'($urandom_range(0, lo - 1));
          5:       q = '0;
          6:       q = '1;
          default: q = LEN_W'($urandom_range(lo, hi));
        endcase
        query_length(q);
        sent++;
      end
    end
  endtask

  initial begin
    rst                 <= 1'b1;
    req_ch.valid        <= 1'b0;
    req_ch.cmd          <= CMD_LOAD;
    req_ch.entry_index  <= '0;
    req_ch.entry_param  <= '0;
    req_ch.entry_length <= '0;
    req_ch.query_length <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.entry_count  <= 8'd2;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_reset_count();
    test_full_depth();
    test_count_clamp();
    test_segment_cases();
    test_random_traffic();

    drain_lookups();
    if (fail_count == 0 && pending_lookups.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      if (pending_lookups.size() != 0)
        $display("%0d expected results never arrived", pending_lookups.size());
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule : tb

// ===== arc_length_param_lookup.f =====
design/alpl_pkg.sv
design/alpl_ifs.sv
design/alpl_div.sv
design/arc_length_param_lookup.sv
tb/tb.sv
